FILE: rtl/core/tpms_pkg.sv
// ============================================================================
// Trapezoid profile package
// Shared constants, register indexes and defaults for the profile planner.
// ============================================================================
`default_nettype none

package tpms_pkg;

    // Default field widths
    localparam int GOAL_BITS_DEF  = 24;
    localparam int SPEED_BITS_DEF = 16;

    // Result field widths
    localparam int RAMP_W = 26;
    localparam int FLAT_W = 34;

    // Milliseconds per second and the bits that the factor needs
    localparam int MS_PER_S = 1000;
    localparam int MS_BITS  = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes
    localparam logic [1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_ACCEL     = 2'd2;

    // Register reset values
    localparam int RST_MIN_SPEED = 0;
    localparam int RST_MAX_SPEED = 500;
    localparam int RST_ACCEL     = 1000;

endpackage

`default_nettype wire

FILE: rtl/core/tpms_if.sv
// ============================================================================
// Trapezoid profile channels
// Valid/ready channels for goal words and profile result words.
// ============================================================================
`default_nettype none

interface tpms_in_if #(
    parameter int GOAL_BITS = tpms_pkg::GOAL_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [GOAL_BITS-1:0] goal_distance;

    modport source (output valid, output goal_distance, input ready);
    modport sink   (input valid, input goal_distance, output ready);
endinterface

interface tpms_out_if;
    import tpms_pkg::*;

    logic              valid;
    logic              ready;
    logic [RAMP_W-1:0] ramp_time_ms;
    logic [FLAT_W-1:0] flat_time_ms;
    logic              is_triangle;

    modport source (output valid, output ramp_time_ms, output flat_time_ms,
                    output is_triangle, input ready);
    modport sink   (input valid, input ramp_time_ms, input flat_time_ms,
                    input is_triangle, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/trapezoid_profile_with_min_speed.sv
// ============================================================================
// Trapezoidal move planner with minimum speed
// Top level: configuration port, classifying front end, queue and back end.
// ============================================================================
// Usage:
// Goal words enter on i_in (valid/ready); one result word per goal leaves on
// o_out in the same order, carrying the ramp time, the flat time and the
// triangle flag. Speeds and acceleration are set through the APB-style port
// (min speed at 0x0, max speed at 0x4, acceleration at 0x8).
// After reset and after every register write the front end squares the
// speeds and divides out the threshold and the full ramp time, one quotient
// bit per cycle; i_in.ready stays low until both quotients are done.
// Afterwards one goal word is accepted per cycle while the queue has room.
// From acceptance a word passes the queue, the root stages, the difference
// stage, the divider stages and the output register on its way to o_out.
// When the receiver stalls, the back-end pipeline holds, the four-entry queue
// fills, and then i_in.ready drops; no word is lost.
// ============================================================================
`default_nettype none

module trapezoid_profile_with_min_speed #(
    parameter int GOAL_BITS  = tpms_pkg::GOAL_BITS_DEF,
    parameter int SPEED_BITS = tpms_pkg::SPEED_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpms_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tpms_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tpms_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    tpms_in_if.sink                              i_in,
    tpms_out_if.source                           o_out
);
    import tpms_pkg::*;

    localparam int QW = SPEED_BITS + GOAL_BITS + 1;

    logic                    w_push;
    logic [QW-1:0]           w_push_data;
    logic                    w_q_full;
    logic                    w_q_valid;
    logic [QW-1:0]           w_q_data;
    logic                    w_pop;
    logic [SPEED_BITS-1:0]   w_vmin;
    logic [SPEED_BITS-1:0]   w_vmax;
    logic [SPEED_BITS-1:0]   w_acc;
    logic [2*SPEED_BITS-1:0] w_vmin_sq;
    logic [RAMP_W-1:0]       w_ramp_full;

    // Registers, precompute and classification.
    tpms_front #(
        .GOAL_BITS  (GOAL_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_in.valid),
        .i_goal      (GOAL_BITS'(i_in.goal_distance)),
        .o_ready     (i_in.ready),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_vmin      (w_vmin),
        .o_vmax      (w_vmax),
        .o_acc       (w_acc),
        .o_vmin_sq   (w_vmin_sq),
        .o_ramp_full (w_ramp_full)
    );

    // Queue between the two halves.
    tpms_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    // Root, scaling and division.
    tpms_back #(
        .GOAL_BITS  (GOAL_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_data      (w_q_data),
        .o_pop       (w_pop),
        .i_vmin      (w_vmin),
        .i_vmax      (w_vmax),
        .i_acc       (w_acc),
        .i_vmin_sq   (w_vmin_sq),
        .i_ramp_full (w_ramp_full),
        .i_ready     (o_out.ready),
        .o_valid     (o_out.valid),
        .o_ramp      (o_out.ramp_time_ms),
        .o_flat      (o_out.flat_time_ms),
        .o_tri       (o_out.is_triangle)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tpms_queue.sv
// ============================================================================
// Trapezoid profile queue
// Small first-in first-out buffer between the classifier and the back end.
// ============================================================================
`default_nettype none

module tpms_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_full
);
    import tpms_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/core/tpms_front.sv
// ============================================================================
// Trapezoid profile front end
// Holds the configuration registers, derives the threshold and the full ramp
// time with a serial divider, and classifies each goal word.
// ============================================================================
`default_nettype none

module tpms_front #(
    parameter int GOAL_BITS  = tpms_pkg::GOAL_BITS_DEF,
    parameter int SPEED_BITS = tpms_pkg::SPEED_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tpms_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tpms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tpms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              i_valid,
    input  wire logic [GOAL_BITS-1:0]              i_goal,
    output logic                                   o_ready,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output logic      [SPEED_BITS+GOAL_BITS:0]     o_push_data,
    output logic      [SPEED_BITS-1:0]             o_vmin,
    output logic      [SPEED_BITS-1:0]             o_vmax,
    output logic      [SPEED_BITS-1:0]             o_acc,
    output logic      [2*SPEED_BITS-1:0]           o_vmin_sq,
    output logic      [tpms_pkg::RAMP_W-1:0]       o_ramp_full
);
    import tpms_pkg::*;

    localparam int S     = SPEED_BITS;
    localparam int G     = GOAL_BITS;
    localparam int V     = S + G;
    localparam int W     = 2 * S + MS_BITS;
    localparam int CW    = (G > 2 * S) ? G : 2 * S;
    localparam int CNT_W = $clog2(W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [S-1:0]     r_vmin;
    logic [S-1:0]     r_vmax;
    logic [S-1:0]     r_acc;
    logic [1:0]       r_state;
    logic             r_dirty;
    logic [S-1:0]     r_vmax_e;
    logic [S-1:0]     r_acc_e;
    logic [2*S-1:0]   r_vmin_sq;
    logic [2*S-1:0]   r_vmax_sq;
    logic [W-1:0]     r_dvd_t;
    logic [W-1:0]     r_dvd_r;
    logic [S-1:0]     r_rem_t;
    logic [S-1:0]     r_rem_r;
    logic [CNT_W-1:0] r_cnt;

    logic             w_wr;
    logic [S:0]       w_tr_t;
    logic [S:0]       w_tr_r;
    logic             w_ge_t;
    logic             w_ge_r;
    logic [S:0]       w_sub_t;
    logic [S:0]       w_sub_r;
    logic             w_gt;
    logic [CW-1:0]    w_goal;
    logic [CW-1:0]    w_thr;
    logic             w_tri;
    logic [V-1:0]     w_val;

    // Register write and read decode.
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= S'(RST_MIN_SPEED);
            r_vmax <= S'(RST_MAX_SPEED);
            r_acc  <= S'(RST_ACCEL);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MIN_SPEED: r_vmin <= pwdata[S-1:0];
                REG_MAX_SPEED: r_vmax <= pwdata[S-1:0];
                REG_ACCEL:     r_acc  <= pwdata[S-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_SPEED: prdata = APB_DATA_W'(r_vmin);
            REG_MAX_SPEED: prdata = APB_DATA_W'(r_vmax);
            REG_ACCEL:     prdata = APB_DATA_W'(r_acc);
            default:       prdata = '0;
        endcase
    end

    // One restoring divide step for the threshold and for the full ramp.
    assign w_tr_t  = {r_rem_t, r_dvd_t[W-1]};
    assign w_tr_r  = {r_rem_r, r_dvd_r[W-1]};
    assign w_ge_t  = (w_tr_t >= {1'b0, r_acc_e});
    assign w_ge_r  = (w_tr_r >= {1'b0, r_acc_e});
    assign w_sub_t = w_tr_t - {1'b0, r_acc_e};
    assign w_sub_r = w_tr_r - {1'b0, r_acc_e};
    assign w_gt    = (r_vmax_e > r_vmin);

    // Sequencer: squares, dividend load, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dirty <= 1'b1;
        end else begin
            if (w_wr) begin
                r_dirty <= 1'b1;
            end else if (r_state == ST_IDLE && r_dirty) begin
                r_dirty <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (r_dirty) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ:   r_state <= ST_LD;
                ST_LD:   r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SQ: begin
                r_vmax_e  <= (r_vmax == '0) ? S'(1) : r_vmax;
                r_acc_e   <= (r_acc == '0) ? S'(1) : r_acc;
                r_vmin_sq <= (2*S)'(r_vmin) * (2*S)'(r_vmin);
                r_vmax_sq <= (r_vmax == '0) ? (2*S)'(1)
                                            : (2*S)'(r_vmax) * (2*S)'(r_vmax);
            end
            ST_LD: begin
                r_dvd_t <= w_gt ? W'(r_vmax_sq - r_vmin_sq) : '0;
                r_dvd_r <= w_gt ? W'(r_vmax_e - r_vmin) * W'(MS_PER_S) : '0;
                r_rem_t <= '0;
                r_rem_r <= '0;
                r_cnt   <= CNT_W'(W);
            end
            ST_DIV: begin
                r_rem_t <= w_ge_t ? w_sub_t[S-1:0] : w_tr_t[S-1:0];
                r_rem_r <= w_ge_r ? w_sub_r[S-1:0] : w_tr_r[S-1:0];
                r_dvd_t <= {r_dvd_t[W-2:0], w_ge_t};
                r_dvd_r <= {r_dvd_r[W-2:0], w_ge_r};
                r_cnt   <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    // Classification of the goal word against the threshold.
    assign w_goal = CW'(i_goal);
    assign w_thr  = CW'(r_dvd_t);
    assign w_tri  = (w_goal <= w_thr);
    assign w_val  = w_tri ? V'(r_acc_e) * V'(i_goal) : V'(w_goal - w_thr);

    assign o_ready     = (r_state == ST_IDLE) && !r_dirty && !i_q_full;
    assign o_push      = i_valid && o_ready;
    assign o_push_data = {w_tri, w_val};
    assign o_vmin      = r_vmin;
    assign o_vmax      = r_vmax_e;
    assign o_acc       = r_acc_e;
    assign o_vmin_sq   = r_vmin_sq;
    assign o_ramp_full = RAMP_W'(r_dvd_r);

endmodule

`default_nettype wire

FILE: rtl/core/tpms_back.sv
// ============================================================================
// Trapezoid profile back end
// Pipelined integer square root, scaling and pipelined divider that turn a
// classified word into the ramp and flat times.
// ============================================================================
`default_nettype none

module tpms_back #(
    parameter int GOAL_BITS  = tpms_pkg::GOAL_BITS_DEF,
    parameter int SPEED_BITS = tpms_pkg::SPEED_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [SPEED_BITS+GOAL_BITS:0]  i_data,
    output logic                                o_pop,
    input  wire logic [SPEED_BITS-1:0]          i_vmin,
    input  wire logic [SPEED_BITS-1:0]          i_vmax,
    input  wire logic [SPEED_BITS-1:0]          i_acc,
    input  wire logic [2*SPEED_BITS-1:0]        i_vmin_sq,
    input  wire logic [tpms_pkg::RAMP_W-1:0]    i_ramp_full,
    input  wire logic                           i_ready,
    output logic                                o_valid,
    output logic      [tpms_pkg::RAMP_W-1:0]    o_ramp,
    output logic      [tpms_pkg::FLAT_W-1:0]    o_flat,
    output logic                                o_tri
);
    import tpms_pkg::*;

    localparam int S  = SPEED_BITS;
    localparam int G  = GOAL_BITS;
    localparam int V  = S + G;
    localparam int R  = ((2 * S > V) ? 2 * S : V) + 1;
    localparam int N  = (R + 1) / 2;
    localparam int RW = N + 3;
    localparam int M  = (N > G) ? N : G;
    localparam int D  = M + MS_BITS;

    // Square root stages
    logic           r_sv    [0:N];
    logic           r_stri  [0:N];
    logic [V-1:0]   r_sval  [0:N];
    logic [2*N-1:0] r_srad  [0:N];
    logic [RW-1:0]  r_srem  [0:N];
    logic [N-1:0]   r_sroot [0:N];
    logic [RW-1:0]  n_srem  [1:N];
    logic [N-1:0]   n_sroot [1:N];
    logic [RW-1:0]  w_sh    [0:N-1];
    logic [RW-1:0]  w_st    [0:N-1];

    // Difference stage
    logic           r_fv;
    logic           r_ftri;
    logic [M-1:0]   r_fdf;

    // Divider stages
    logic           r_dv    [0:D];
    logic           r_dtri  [0:D];
    logic [S-1:0]   r_drem  [0:D];
    logic [D-1:0]   r_ddvd  [0:D];
    logic [S-1:0]   n_drem  [1:D];
    logic [D-1:0]   n_ddvd  [1:D];
    logic [S:0]     w_dt    [0:D-1];
    logic [S-1:0]   w_dd    [0:D-1];

    // Output register
    logic              r_ov;
    logic              r_otri;
    logic [RAMP_W-1:0] r_oramp;
    logic [FLAT_W-1:0] r_oflat;

    logic           w_adv;
    logic [D-1:0]   w_q;

    // The whole pipeline moves when the output register can take a word.
    assign w_adv = !r_ov || i_ready;
    assign o_pop = w_adv && i_valid;

    // One root bit per stage.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_sh[k] = {r_srem[k][N:0], r_srad[k][2*N-1:2*N-2]};
            w_st[k] = {1'b0, r_sroot[k], 2'b01};
            if (w_sh[k] >= w_st[k]) begin
                n_srem[k+1]  = w_sh[k] - w_st[k];
                n_sroot[k+1] = {r_sroot[k][N-2:0], 1'b1};
            end else begin
                n_srem[k+1]  = w_sh[k];
                n_sroot[k+1] = {r_sroot[k][N-2:0], 1'b0};
            end
        end
    end

    // One quotient bit per stage; triangles divide by the acceleration.
    always_comb begin
        for (int k = 0; k < D; k++) begin
            w_dd[k] = r_dtri[k] ? i_acc : i_vmax;
            w_dt[k] = {r_drem[k], r_ddvd[k][D-1]};
            if (w_dt[k] >= {1'b0, w_dd[k]}) begin
                n_drem[k+1] = S'(w_dt[k] - {1'b0, w_dd[k]});
                n_ddvd[k+1] = {r_ddvd[k][D-2:0], 1'b1};
            end else begin
                n_drem[k+1] = w_dt[k][S-1:0];
                n_ddvd[k+1] = {r_ddvd[k][D-2:0], 1'b0};
            end
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_sv[k] <= 1'b0;
            end
            for (int k = 0; k <= D; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= i_valid;
            for (int k = 0; k < N; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_fv    <= r_sv[N];
            r_dv[0] <= r_fv;
            for (int k = 0; k < D; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ov <= r_dv[D];
        end
    end

    // Payload of every stage.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_stri[0]  <= i_data[V];
            r_sval[0]  <= i_data[V-1:0];
            r_srad[0]  <= (2*N)'(i_vmin_sq) + (2*N)'(i_data[V-1:0]);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            for (int k = 0; k < N; k++) begin
                r_stri[k+1]  <= r_stri[k];
                r_sval[k+1]  <= r_sval[k];
                r_srad[k+1]  <= {r_srad[k][2*N-3:0], 2'b00};
                r_srem[k+1]  <= n_srem[k+1];
                r_sroot[k+1] <= n_sroot[k+1];
            end

            // Root minus start speed for triangles, distance past threshold else.
            r_ftri <= r_stri[N];
            r_fdf  <= r_stri[N] ? M'(r_sroot[N]) - M'(i_vmin) : M'(r_sval[N]);

            r_dtri[0] <= r_ftri;
            r_ddvd[0] <= D'(r_fdf) * D'(MS_PER_S);
            r_drem[0] <= '0;
            for (int k = 0; k < D; k++) begin
                r_dtri[k+1] <= r_dtri[k];
                r_drem[k+1] <= n_drem[k+1];
                r_ddvd[k+1] <= n_ddvd[k+1];
            end

            r_otri  <= r_dtri[D];
            r_oramp <= r_dtri[D] ? RAMP_W'(w_q) : i_ramp_full;
            r_oflat <= r_dtri[D] ? '0 : FLAT_W'(w_q);
        end
    end

    assign w_q     = r_ddvd[D];
    assign o_valid = r_ov;
    assign o_ramp  = r_oramp;
    assign o_flat  = r_oflat;
    assign o_tri   = r_otri;

endmodule

`default_nettype wire
